// ===== design/bezier_point_and_heading_macros.svh =====
// Assertion macros for the Bezier point and heading block.
`ifndef BEZIER_POINT_AND_HEADING_MACROS_SVH
`define BEZIER_POINT_AND_HEADING_MACROS_SVH
`ifndef SYNTHESIS
`define BPH_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define BPH_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define BPH_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define BPH_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

// ===== design/bph_pkg.sv =====
// Shared types, constants and helpers for the Bezier point and heading block.
package bph_pkg;
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_TAB_LEN  = 24;
    localparam int LERP_STAGES   = 4;
    localparam int PIPE_DEPTH    = LERP_STAGES + CORDIC_STAGES + 1;
    localparam int CW            = 45;   // CORDIC x/y width
    localparam int ZW            = 34;   // Q4.30 angle accumulator
    localparam logic signed [15:0] PI_Q13      = 16'sd25736;
    localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
    localparam logic [16:0] ONE_T = 17'd65536;
    localparam logic [1:0] CMD_LINE = 2'd0;
    localparam logic [1:0] CMD_QUAD = 2'd1;

    typedef logic signed [23:0] t_coord;

    // CORDIC state handed from cell to cell
    typedef struct packed {
        logic                 valid;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 neg;    // dy < 0: add pi
        logic                 dyz;    // dy == 0
        logic                 axlt;   // ax < bx
        t_coord               rx;
        t_coord               ry;
    } t_cord;

    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        case (i)
            0: atan_q30 = 34'sd843314857;
            1: atan_q30 = 34'sd497837829;
            2: atan_q30 = 34'sd263043837;
            3: atan_q30 = 34'sd133525159;
            4: atan_q30 = 34'sd67021687;
            5: atan_q30 = 34'sd33543516;
            6: atan_q30 = 34'sd16775851;
            7: atan_q30 = 34'sd8388437;
            8: atan_q30 = 34'sd4194283;
            9: atan_q30 = 34'sd2097149;
            default: atan_q30 = 34'sd1 <<< (30 - i);
        endcase
    endfunction

    // a + round((b - a) * t / 2^16), saturated
    function automatic t_coord lerp(input t_coord a, input t_coord b, input logic [16:0] t);
        logic signed [24:0] d;
        logic signed [42:0] p;
        logic signed [26:0] s;
        d = 25'(b) - 25'(a);
        p = 43'(d) * $signed({1'b0, t}) + 43'sd32768;
        s = 27'(a) + 27'(p >>> 16);
        if (s > 27'sd8388607) lerp = 24'sh7FFFFF;
        else if (s < -27'sd8388608) lerp = 24'sh800000;
        else lerp = s[23:0];
    endfunction
endpackage

// ===== design/bph_cordic_cell.sv =====
// One vectoring CORDIC iteration, registered.
module bph_cordic_cell import bph_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [4:0] i_stage,
    input  t_cord      i_d,
    output t_cord      o_d
);
    t_cord r_d, n_d;
    always_comb begin
        n_d = i_d;
        if (i_d.y < 0) begin
            n_d.x = i_d.x - (i_d.y >>> i_stage);
            n_d.y = i_d.y + (i_d.x >>> i_stage);
            n_d.z = i_d.z - atan_q30(int'(i_stage));
        end else begin
            n_d.x = i_d.x + (i_d.y >>> i_stage);
            n_d.y = i_d.y - (i_d.x >>> i_stage);
            n_d.z = i_d.z + atan_q30(int'(i_stage));
        end
    end
    always_ff @(posedge i_clk) begin
        r_d <= n_d;
        if (!i_rst_n) r_d.valid <= 1'b0;
    end
    assign o_d = r_d;
endmodule

// ===== design/bezier_point_and_heading.sv =====
// Bezier point and heading: four input and lerp stages, 16 CORDIC cells, output stage.
// Path from start to o_valid: four input and interpolation stages,
// CORDIC_STAGES iteration cells, one angle rounding stage.
// Throughput: one item per cycle; busy is always low, tied off in this module.
// Reset: synchronous active low, clears the valid bits of every stage.
// The receiver cannot stall; each result shows for one cycle with o_valid.
`include "bezier_point_and_heading_macros.svh"
module bezier_point_and_heading import bph_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [1:0]    i_command,
    input  t_coord        i_ctrl_x0, input t_coord i_ctrl_y0,
    input  t_coord        i_ctrl_x1, input t_coord i_ctrl_y1,
    input  t_coord        i_ctrl_x2, input t_coord i_ctrl_y2,
    input  t_coord        i_ctrl_x3, input t_coord i_ctrl_y3,
    input  logic [16:0]   i_param_t,
    output logic          o_valid,
    output t_coord        o_pos_x,
    output t_coord        o_pos_y,
    output logic signed [15:0] o_heading
);
    assign busy = 1'b0;
    // stage 1: latch inputs, clamp t
    logic r_v1, r_v2, r_v3, r_v4;
    logic [1:0] r_cmd1, r_cmd2;
    logic [16:0] r_t1, r_t2, r_t3;
    t_coord r_px[4], r_py[4];
    t_coord r_x1, r_y1, r_x2, r_y2, r_x3, r_y3;
    t_coord r_ax, r_ay, r_bx, r_by;
    always_ff @(posedge i_clk) begin
        r_v1 <= start; r_v2 <= r_v1; r_v3 <= r_v2;
        r_cmd1 <= i_command;
        r_t1 <= (i_param_t > ONE_T) ? ONE_T : i_param_t;
        r_px[0] <= i_ctrl_x0; r_py[0] <= i_ctrl_y0;
        r_px[1] <= i_ctrl_x1; r_py[1] <= i_ctrl_y1;
        r_px[2] <= i_ctrl_x2; r_py[2] <= i_ctrl_y2;
        r_px[3] <= i_ctrl_x3; r_py[3] <= i_ctrl_y3;
        // stage 2: first lerps, or pass-through for a line
        r_cmd2 <= r_cmd1; r_t2 <= r_t1;
        if (r_cmd1 == CMD_LINE) begin
            r_x1 <= r_px[0]; r_y1 <= r_py[0]; r_x2 <= r_px[1]; r_y2 <= r_py[1];
        end else begin
            r_x1 <= lerp(r_px[0], r_px[1], r_t1); r_y1 <= lerp(r_py[0], r_py[1], r_t1);
            r_x2 <= lerp(r_px[1], r_px[2], r_t1); r_y2 <= lerp(r_py[1], r_py[2], r_t1);
        end
        r_x3 <= lerp(r_px[2], r_px[3], r_t1); r_y3 <= lerp(r_py[2], r_py[3], r_t1);
        // stage 3: second lerps for a cubic
        r_t3 <= r_t2;
        if (r_cmd2 == CMD_LINE || r_cmd2 == CMD_QUAD) begin
            r_ax <= r_x1; r_ay <= r_y1; r_bx <= r_x2; r_by <= r_y2;
        end else begin
            r_ax <= lerp(r_x1, r_x2, r_t2); r_ay <= lerp(r_y1, r_y2, r_t2);
            r_bx <= lerp(r_x2, r_x3, r_t2); r_by <= lerp(r_y2, r_y3, r_t2);
        end
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
        end
    end
    // stage 4: final lerp and CORDIC seed
    t_cord r_seed, n_seed;
    logic signed [24:0] w_dx, w_dy;
    always_comb begin
        w_dx = 25'(r_ax) - 25'(r_bx);
        w_dy = 25'(r_ay) - 25'(r_by);
        n_seed.valid = r_v3;
        n_seed.neg   = w_dy < 0;
        n_seed.dyz   = w_dy == 0;
        n_seed.axlt  = r_ax < r_bx;
        n_seed.x     = (w_dy < 0) ? -(CW'(w_dy) <<< 16) : (CW'(w_dy) <<< 16);
        n_seed.y     = (w_dy < 0) ? -(CW'(w_dx) <<< 16) : (CW'(w_dx) <<< 16);
        n_seed.z     = '0;
        n_seed.rx    = lerp(r_ax, r_bx, r_t3);
        n_seed.ry    = lerp(r_ay, r_by, r_t3);
    end
    always_ff @(posedge i_clk) begin
        r_seed <= n_seed;
        if (!i_rst_n) r_seed.valid <= 1'b0;
    end
    assign r_v4 = r_seed.valid;
    t_cord w_c[CORDIC_STAGES+1];
    assign w_c[0] = r_seed;
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        bph_cordic_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_stage(5'(g)),
            .i_d(w_c[g]), .o_d(w_c[g+1]));
    end
    // output stage: round angle, form heading
    t_cord w_e;
    logic signed [ZW-1:0] w_zr;
    logic signed [15:0] w_a, n_head;
    always_comb begin
        w_e  = w_c[CORDIC_STAGES];
        w_zr = (w_e.z + ZW'(65536)) >>> 17;
        w_a  = w_zr[15:0];
        if (w_e.dyz) n_head = w_e.axlt ? 16'sd0 : -(HALF_PI_Q13 + HALF_PI_Q13);
        else if (w_e.neg) n_head = PI_Q13 - w_a - HALF_PI_Q13;
        else n_head = -w_a - HALF_PI_Q13;
    end
    logic r_ov;
    t_coord r_ox, r_oy;
    logic signed [15:0] r_oh;
    always_ff @(posedge i_clk) begin
        r_ov <= w_e.valid; r_ox <= w_e.rx; r_oy <= w_e.ry; r_oh <= n_head;
        if (!i_rst_n) r_ov <= 1'b0;
    end
    assign o_valid = r_ov; assign o_pos_x = r_ox; assign o_pos_y = r_oy;
    assign o_heading = r_oh;

    `BPH_ASSERT_NXT(a_v2, i_clk, i_rst_n, r_v1, r_v2)
    `BPH_ASSERT_NXT(a_seed, i_clk, i_rst_n, r_v3, r_v4)
    `BPH_ASSERT_IMP(a_hrange, i_clk, i_rst_n, o_valid,
        o_heading <= PI_Q13 && o_heading >= -PI_Q13)
endmodule

// ===== tb/bezier_point_and_heading_tb.sv =====
// Self-checking testbench for the Bezier point and heading evaluator.
module bezier_point_and_heading_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bph_pkg::*;

    typedef struct {
        logic [1:0]  cmd;
        t_coord      px[4];
        t_coord      py[4];
        logic [16:0] t;
    } t_curve_item;

    typedef struct {
        t_coord             x;
        t_coord             y;
        logic signed [15:0] hdg;
    } t_curve_point;

    // Tracks points still due from the block and compares arriving ones.
    class t_curve_scoreboard;
        t_curve_point pending[$];
        int           errors;

        static function longint fdiv(longint v, int s);
            return v >>> s;
        endfunction

        static function longint blend(longint a, longint b, longint t);
            longint r;
            r = a + fdiv((b - a) * t + 32768, 16);
            if (r > 8388607) r = 8388607;
            if (r < -8388608) r = -8388608;
            return r;
        endfunction

        static function longint atan_step(int i);
            longint tab[10];
            tab = '{843314857, 497837829, 263043837, 133525159, 67021687,
                    33543516, 16775851, 8388437, 4194283, 2097149};
            return (i < 10) ? tab[i] : (64'sd1 <<< (30 - i));
        endfunction

        static function longint arctan(longint num, longint den);
            longint x, y, z, xs, ys;
            x = den * 65536;
            y = num * 65536;
            z = 0;
            for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
                xs = fdiv(x, i);
                ys = fdiv(y, i);
                if (y < 0) begin
                    x = x - ys; y = y + xs; z -= atan_step(i);
                end else begin
                    x = x + ys; y = y - xs; z += atan_step(i);
                end
            end
            return fdiv(z + 65536, 17);
        endfunction

        function void note_item(t_curve_item it);
            longint p[4], q[4], t, ax, ay, bx, by, dx, dy, base;
            longint x1, y1, x2, y2, x3, y3;
            t_curve_point r;
            for (int k = 0; k < 4; k++) begin
                p[k] = it.px[k];
                q[k] = it.py[k];
            end
            t = (it.t > ONE_T) ? 65536 : it.t;
            if (it.cmd == CMD_LINE) begin
                ax = p[0]; ay = q[0]; bx = p[1]; by = q[1];
            end else if (it.cmd == CMD_QUAD) begin
                ax = blend(p[0], p[1], t); ay = blend(q[0], q[1], t);
                bx = blend(p[1], p[2], t); by = blend(q[1], q[2], t);
            end else begin
                x1 = blend(p[0], p[1], t); y1 = blend(q[0], q[1], t);
                x2 = blend(p[1], p[2], t); y2 = blend(q[1], q[2], t);
                x3 = blend(p[2], p[3], t); y3 = blend(q[2], q[3], t);
                ax = blend(x1, x2, t); ay = blend(y1, y2, t);
                bx = blend(x2, x3, t); by = blend(y2, y3, t);
            end
            dx = ax - bx;
            dy = ay - by;
            if (dy == 0) base = (ax < bx) ? HALF_PI_Q13 : -HALF_PI_Q13;
            else if (dy > 0) base = -arctan(dx, dy);
            else base = PI_Q13 - arctan(-dx, -dy);
            r.x = t_coord'(blend(ax, bx, t));
            r.y = t_coord'(blend(ay, by, t));
            r.hdg = 16'(base - HALF_PI_Q13);
            pending.push_back(r);
        endfunction

        function void check_point(t_curve_point got);
            t_curve_point want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected point x=%0d y=%0d h=%0d",
                         $time, got.x, got.y, got.hdg);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.x !== want.x) begin
                $display("%0t: pos_x expected %0d actual %0d", $time, want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $display("%0t: pos_y expected %0d actual %0d", $time, want.y, got.y);
                errors++;
            end
            if (got.hdg !== want.hdg) begin
                $display("%0t: heading expected %0d actual %0d",
                         $time, want.hdg, got.hdg);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_command;
    t_coord             i_ctrl_x0, i_ctrl_y0, i_ctrl_x1, i_ctrl_y1;
    t_coord             i_ctrl_x2, i_ctrl_y2, i_ctrl_x3, i_ctrl_y3;
    logic [16:0]        i_param_t;
    logic               o_valid;
    t_coord             o_pos_x, o_pos_y;
    logic signed [15:0] o_heading;

    t_curve_scoreboard sb;
    int                idle_pct;

    bezier_point_and_heading u_dut (.*);

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    initial sb = new();

    always @(posedge i_clk) begin
        t_curve_point got;
        if (i_rst_n && o_valid) begin
            got.x = o_pos_x;
            got.y = o_pos_y;
            got.hdg = o_heading;
            sb.check_point(got);
        end
    end

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF - t_coord'($urandom_range(0, 3));
            1: return 24'sh800000 + t_coord'($urandom_range(0, 3));
            2: return t_coord'($urandom_range(0, 2047)) - 24'sd1024;
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic logic [16:0] rand_t();
        case ($urandom_range(0, 7))
            0: return 17'd0;
            1: return ONE_T;
            2: return 17'($urandom);
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // Present one item and hold it until accepted; called at a falling edge.
    task automatic send_item(t_curve_item it);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start     <= 1'b1;
        i_command <= it.cmd;
        i_ctrl_x0 <= it.px[0]; i_ctrl_y0 <= it.py[0];
        i_ctrl_x1 <= it.px[1]; i_ctrl_y1 <= it.py[1];
        i_ctrl_x2 <= it.px[2]; i_ctrl_y2 <= it.py[2];
        i_ctrl_x3 <= it.px[3]; i_ctrl_y3 <= it.py[3];
        i_param_t <= it.t;
        do @(posedge i_clk); while (busy);
        sb.note_item(it);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        t_curve_item it;
        it.cmd = 2'($urandom);
        for (int k = 0; k < 4; k++) begin
            it.px[k] = rand_coord();
            it.py[k] = ($urandom_range(0, 9) == 0) ? it.px[k] : rand_coord();
        end
        // flat segments exercise the zero dy heading path
        if ($urandom_range(0, 5) == 0) begin
            for (int k = 1; k < 4; k++) it.py[k] = it.py[0];
        end
        it.t = rand_t();
        send_item(it);
    endtask

    task automatic send_line(t_coord x0, t_coord y0, t_coord x1, t_coord y1,
                             logic [1:0] cmd, logic [16:0] t);
        t_curve_item it;
        it.cmd = cmd;
        it.px = '{x0, x1, rand_coord(), rand_coord()};
        it.py = '{y0, y1, rand_coord(), rand_coord()};
        it.t = t;
        send_item(it);
    endtask

    initial begin
        start = 1'b0; i_command = CMD_LINE; i_param_t = '0;
        i_ctrl_x0 = '0; i_ctrl_y0 = '0; i_ctrl_x1 = '0; i_ctrl_y1 = '0;
        i_ctrl_x2 = '0; i_ctrl_y2 = '0; i_ctrl_x3 = '0; i_ctrl_y3 = '0;
        i_rst_n = 1'b0;
        idle_pct = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero dx and dy, horizontal both ways, vertical, extremes, t above one
        send_line(24'sd0, 24'sd0, 24'sd0, 24'sd0, CMD_LINE, 17'd0);
        send_line(24'sd0, 24'sd0, 24'sd256, 24'sd0, CMD_LINE, 17'd32768);
        send_line(24'sd256, 24'sd0, 24'sd0, 24'sd0, CMD_LINE, ONE_T);
        send_line(24'sd0, 24'sd0, 24'sd0, 24'sd256, CMD_LINE, 17'd16384);
        send_line(24'sd0, 24'sd256, 24'sd0, 24'sd0, CMD_LINE, 17'd16384);
        send_line(24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, CMD_LINE,
                  ONE_T);
        send_line(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, CMD_LINE,
                  17'h1FFFF);
        send_line(24'sd100, -24'sd300, -24'sd500, 24'sd700, CMD_LINE, 17'd70000);
        for (int c = 0; c < 4; c++) begin
            send_line(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000,
                      2'(c), 17'd40000);
            send_line(-24'sd1, 24'sd1, 24'sd1, -24'sd1, 2'(c), 17'h1FFFF);
            send_line(24'sd0, 24'sd0, 24'sd0, 24'sd0, 2'(c), 17'd1);
        end
        for (int n = 0; n < 550; n++) begin
            case (n / 110)
                0: idle_pct = 0;
                1: idle_pct = 66;
                2: idle_pct = 22;
                3: idle_pct = 0;
                default: idle_pct = 66;
            endcase
            send_random();
        end
        start <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (sb.errors == 0) $display("bezier_point_and_heading_tb: PASS");
        else $display("bezier_point_and_heading_tb: FAIL");
        $finish;
    end

    initial begin
        #2ms;
        $display("bezier_point_and_heading_tb: FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+design
design/bph_pkg.sv
design/bph_cordic_cell.sv
design/bezier_point_and_heading.sv
tb/bezier_point_and_heading_tb.sv
